// ----- rtl/sbd_pkg.sv -----
// Shared types, constants and the divide-by-nine rounding function of the box downsampler.
package sbd_pkg;

	// channel and pixel layout
	localparam int unsigned CH_W = 8;
	localparam int unsigned NUM_CH = 3;
	localparam int unsigned PIX_W = NUM_CH * CH_W;

	// accumulator widths: one sub-row of three, two sub-rows, full block of nine
	localparam int unsigned PART_W = 10;
	localparam int unsigned COL_SUM_W = 11;
	localparam int unsigned TOTAL_W = 12;

	// configuration and raster counter widths
	localparam int unsigned WIDTH_REG_W = 11;
	localparam int unsigned HEIGHT_REG_W = 13;
	localparam int unsigned CFG_DATA_W = 13;
	localparam int unsigned DIM_W = 13;
	localparam int unsigned ROW_W = 12;
	localparam int unsigned MAX_OUT_HEIGHT = 4096;

	// rounding divide by nine: (x + 4) * ceil(2^16 / 9) >> 16, exact for x up to 2299, where the quotient fits a channel
	localparam int unsigned ROUND_BIAS = 4;
	localparam int unsigned RECIP9 = 7282;
	localparam int unsigned RECIP_SHIFT = 16;
	localparam int unsigned PROD_W = TOTAL_W + RECIP_SHIFT;

	typedef logic [1:0] sub_t;
	localparam sub_t SUB_FIRST = 2'd0;
	localparam sub_t SUB_MID = 2'd1;
	localparam sub_t SUB_LAST = 2'd2;

	typedef enum logic {
		REG_OUT_WIDTH = 1'b0,
		REG_OUT_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef logic [CH_W-1:0] chan_t;
	// index 0 is red, 1 green, 2 blue; red lands in the low bits
	typedef logic [NUM_CH-1:0][CH_W-1:0] pixel_t;

	// position of one accepted pixel inside its block and frame
	typedef struct packed {
		sub_t sub_col;
		sub_t sub_row;
		logic frame_last;
	} tag_t;

	function automatic chan_t div9_round(input logic [TOTAL_W-1:0] total);
		logic [TOTAL_W-1:0] biased;
		logic [PROD_W-1:0] prod;
		biased = total + TOTAL_W'(ROUND_BIAS);
		prod = PROD_W'(biased) * PROD_W'(RECIP9);
		return prod[RECIP_SHIFT +: CH_W];
	endfunction

endpackage

// ----- rtl/sbd_raster.sv -----
// Configuration registers and raster position counters of the box downsampler.
module sbd_raster #(
	parameter int MAX_OUT_WIDTH = 1024,
	parameter int COL_W = 10
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [sbd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           accept,
	output logic [COL_W-1:0]               col,
	output sbd_pkg::tag_t                  tag
);
	import sbd_pkg::*;

	logic [WIDTH_REG_W-1:0]  out_width_q;
	logic [HEIGHT_REG_W-1:0] out_height_q;
	sub_t                    sub_col_q;
	sub_t                    sub_row_q;
	logic [COL_W-1:0]        col_q;
	logic [ROW_W-1:0]        row_q;
	logic [DIM_W-1:0]        w_eff;
	logic [DIM_W-1:0]        h_eff;
	logic                    last_col;
	logic                    last_row;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_width_q <= WIDTH_REG_W'(1024);
			out_height_q <= HEIGHT_REG_W'(1024);
		end else if (cfg_we) begin
			if (cfg_index == REG_OUT_WIDTH) begin
				out_width_q <= cfg_data[WIDTH_REG_W-1:0];
			end else begin
				out_height_q <= cfg_data[HEIGHT_REG_W-1:0];
			end
		end
	end

	// clamp dimensions to the supported range, zero acts as one
	always_comb begin
		if (out_width_q == '0) begin
			w_eff = DIM_W'(1);
		end else if (DIM_W'(out_width_q) > DIM_W'(MAX_OUT_WIDTH)) begin
			w_eff = DIM_W'(MAX_OUT_WIDTH);
		end else begin
			w_eff = DIM_W'(out_width_q);
		end
		if (out_height_q == '0) begin
			h_eff = DIM_W'(1);
		end else if (DIM_W'(out_height_q) > DIM_W'(MAX_OUT_HEIGHT)) begin
			h_eff = DIM_W'(MAX_OUT_HEIGHT);
		end else begin
			h_eff = DIM_W'(out_height_q);
		end
	end

	assign last_col = (DIM_W'(col_q) + DIM_W'(1)) >= w_eff;
	assign last_row = (DIM_W'(row_q) + DIM_W'(1)) >= h_eff;

	assign col = col_q;
	assign tag.sub_col = sub_col_q;
	assign tag.sub_row = sub_row_q;
	assign tag.frame_last = last_col && last_row;

	// advance the raster position on each transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_col_q <= SUB_FIRST;
			sub_row_q <= SUB_FIRST;
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (sub_col_q != SUB_LAST) begin
				sub_col_q <= sub_col_q + 2'd1;
			end else begin
				sub_col_q <= SUB_FIRST;
				if (!last_col) begin
					col_q <= col_q + COL_W'(1);
				end else begin
					col_q <= '0;
					if (sub_row_q != SUB_LAST) begin
						sub_row_q <= sub_row_q + 2'd1;
					end else begin
						sub_row_q <= SUB_FIRST;
						row_q <= last_row ? '0 : row_q + ROW_W'(1);
					end
				end
			end
		end
	end

	a_sub_range: assert property (@(posedge clk) disable iff (!arst_n)
		sub_col_q <= SUB_LAST && sub_row_q <= SUB_LAST)
		else $error("sub-block position out of range");

	a_sub_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept && sub_col_q != SUB_LAST |=>
		sub_col_q == $past(sub_col_q) + 2'd1 && col_q == $past(col_q))
		else $error("column moved inside a block");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && tag.frame_last && sub_col_q == SUB_LAST && sub_row_q == SUB_LAST |=>
		sub_col_q == SUB_FIRST && sub_row_q == SUB_FIRST && col_q == '0 && row_q == '0)
		else $error("raster did not wrap after last pixel of frame");

	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable({sub_col_q, sub_row_q, col_q, row_q}))
		else $error("raster moved without a transaction");

endmodule

// ----- rtl/sbd_accum.sv -----
// Column-sum line store, row partial sums, block average and output register.
module sbd_accum #(
	parameter int MAX_OUT_WIDTH = 1024,
	parameter int COL_W = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  sbd_pkg::pixel_t        in_pix,
	input  sbd_pkg::tag_t          in_tag,
	input  logic [COL_W-1:0]       in_col,
	output logic                   out_valid,
	input  logic                   out_ready,
	output sbd_pkg::pixel_t        out_pix,
	output logic                   out_last
);
	import sbd_pkg::*;

	localparam int STORE_W = NUM_CH * COL_SUM_W;

	logic                                     accept;
	logic [COL_W-1:0]                         rd_addr;
	logic                                     valid_s1;
	pixel_t                                   pix_s1;
	tag_t                                     tag_s1;
	logic [COL_W-1:0]                         col_s1;
	logic                                     emit_s1;
	logic                                     fire_s1;
	logic                                     mem_we;
	logic [STORE_W-1:0]                       mem [MAX_OUT_WIDTH];
	logic [NUM_CH-1:0][COL_SUM_W-1:0]         rd_q;
	logic [NUM_CH-1:0][COL_SUM_W-1:0]         wdata;
	logic [NUM_CH-1:0][PART_W-1:0]            partial_q;
	logic [NUM_CH-1:0][PART_W-1:0]            part;
	pixel_t                                   avg;
	logic                                     valid_s2;
	pixel_t                                   pix_s2;
	logic                                     last_s2;

	assign accept = in_valid && in_ready;
	assign emit_s1 = tag_s1.sub_col == SUB_LAST && tag_s1.sub_row == SUB_LAST;
	assign fire_s1 = valid_s1 && (!emit_s1 || !valid_s2 || out_ready);
	assign in_ready = !valid_s1 || fire_s1;
	assign mem_we = fire_s1 && tag_s1.sub_col == SUB_LAST && tag_s1.sub_row != SUB_LAST;

	// keep the store address inside the store
	assign rd_addr = ({1'b0, in_col} > (COL_W+1)'(MAX_OUT_WIDTH - 1)) ?
		COL_W'(MAX_OUT_WIDTH - 1) : in_col;

	// input stage: capture the transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= in_pix;
			tag_s1 <= in_tag;
			col_s1 <= rd_addr;
		end
	end

	// line store: read with the transaction, write back the column sum of the first one or two sub-rows
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[col_s1] <= wdata;
		end
		if (accept) begin
			rd_q <= mem[rd_addr];
		end
	end

	// per-channel sums and rounded average
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			if (tag_s1.sub_col == SUB_FIRST) begin
				part[c] = PART_W'(pix_s1[c]);
			end else begin
				part[c] = partial_q[c] + PART_W'(pix_s1[c]);
			end
			if (tag_s1.sub_row == SUB_FIRST) begin
				wdata[c] = COL_SUM_W'(part[c]);
			end else begin
				wdata[c] = rd_q[c] + COL_SUM_W'(part[c]);
			end
			avg[c] = div9_round(TOTAL_W'(rd_q[c]) + TOTAL_W'(part[c]));
		end
	end

	// hold the running sub-row sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
		end else if (fire_s1 && tag_s1.sub_col != SUB_LAST) begin
			partial_q <= part;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire_s1 && emit_s1) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && emit_s1) begin
			pix_s2 <= avg;
			last_s2 <= tag_s1.frame_last;
		end
	end

	assign out_valid = valid_s2;
	assign out_pix = pix_s2;
	assign out_last = last_s2;

endmodule

// ----- rtl/supersample_box_downsample_3x3.sv -----
// Top level of the 3x3 box-filter downsampler for supersampled RGB streams.
//
//  Channel   Direction  Payload
//  s_axis    in         tdata = red_in, green_in, blue_in (hi-res pixel, raster order)
//  m_axis    out        tdata = red_out, green_out, blue_out; tlast = frame_done
//  cfg       in         cfg_index 0 = out_width, 1 = out_height; cfg_data
//
//  One hi-res pixel is taken per clock; the line store has one read and one write port:
//  it is read with each transaction and written as the last pixel of a block's first or
//  second sub-row leaves the input register; a block's last pixel loads the output register.
//  Reset clears the raster counters and the row partial; the line store needs none.
//  A stall on m_axis holds the output; s_axis stalls only when a finished result also waits.
module supersample_box_downsample_3x3 #(
	parameter int MAX_OUT_WIDTH = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [sbd_pkg::PIX_W-1:0]      s_axis_tdata,  // red_in, green_in, blue_in
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [sbd_pkg::PIX_W-1:0]      m_axis_tdata,  // red_out, green_out, blue_out
	output logic                           m_axis_tlast,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [sbd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sbd_pkg::*;

	localparam int COL_W = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;

	logic             accept;
	logic [COL_W-1:0] col;
	tag_t             tag;
	pixel_t           out_pix;

	assign accept = s_axis_tvalid && s_axis_tready;

	sbd_raster #(
		.MAX_OUT_WIDTH(MAX_OUT_WIDTH),
		.COL_W(COL_W)
	) u_raster (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.accept(accept),
		.col(col),
		.tag(tag)
	);

	sbd_accum #(
		.MAX_OUT_WIDTH(MAX_OUT_WIDTH),
		.COL_W(COL_W)
	) u_accum (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_pix(pixel_t'(s_axis_tdata)),
		.in_tag(tag),
		.in_col(col),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_pix(out_pix),
		.out_last(m_axis_tlast)
	);

	assign m_axis_tdata = PIX_W'(out_pix);

endmodule

// ----- bench/supersample_box_downsample_3x3_tb.sv -----
// Testbench for the 3x3 box-filter downsampler: randomized pixel streams checked against a predictor.
`timescale 1ns / 1ps

module supersample_box_downsample_3x3_tb;
	import sbd_pkg::*;

	localparam int unsigned MAX_W = 1024;
	localparam int unsigned COL_W = 10;
	localparam int unsigned BLOCK_AREA = 9;
	localparam int unsigned NUM_PHASES = 12;
	localparam int unsigned PRESSURE_PHASE = 4;
	localparam int unsigned HOLD_OFF_CYCLES = 300;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned CYCLE_LIMIT = 200000;

	// one predicted output pixel
	typedef struct {
		pixel_t chans;
		logic   frame_done;
	} box_avg_t;

	// Predict block averages from accepted pixels and match them against output transactions.
	class box_avg_board;
		int unsigned reg_width;
		int unsigned reg_height;
		logic [COL_SUM_W-1:0] col_sum [MAX_W][NUM_CH];
		logic [PART_W-1:0] row_part [NUM_CH];
		sub_t sub_col;
		sub_t sub_row;
		logic [COL_W-1:0] out_col;
		logic [ROW_W-1:0] out_row;
		int unsigned written_prefix;
		box_avg_t avg_queue [$];
		int fail_count;

		function new();
			reg_width = 1024;
			reg_height = 1024;
			foreach (row_part[c]) row_part[c] = '0;
			sub_col = SUB_FIRST;
			sub_row = SUB_FIRST;
			out_col = '0;
			out_row = '0;
			written_prefix = 0;
			fail_count = 0;
		endfunction

		function int unsigned eff_width(int unsigned reg_val);
			if (reg_val < 1) return 1;
			if (reg_val > MAX_W) return MAX_W;
			return reg_val;
		endfunction

		function void set_dims(int unsigned w, int unsigned h);
			reg_width = w;
			reg_height = h;
		endfunction

		// A new width must not make the rest of this block row read a never-written column.
		function bit width_safe(int unsigned reg_val);
			return (sub_row == SUB_FIRST) || (eff_width(reg_val) <= written_prefix);
		endfunction

		function int pending();
			return avg_queue.size();
		endfunction

		// Accumulate one accepted pixel; queue an average when it closes a block.
		function void note_pixel(pixel_t px);
			int unsigned w;
			int unsigned h;
			int unsigned part;
			int unsigned total;
			int unsigned col;
			int c;
			bit last_col;
			bit last_row;
			bit emit;
			bit wrote;
			box_avg_t avg;
			w = eff_width(reg_width);
			h = (reg_height < 1) ? 1 : ((reg_height > MAX_OUT_HEIGHT) ? MAX_OUT_HEIGHT : reg_height);
			last_col = (int'(out_col) + 1 >= w);
			last_row = (int'(out_row) + 1 >= h);
			col = 32'(out_col);
			emit = 1'b0;
			wrote = 1'b0;
			avg.chans = '0;
			for (c = 0; c < NUM_CH; c++) begin
				part = (sub_col == SUB_FIRST) ? 32'(px[c]) : 32'(row_part[c]) + 32'(px[c]);
				if (sub_col != SUB_LAST) begin
					row_part[c] = part[PART_W-1:0];
				end else if (sub_row == SUB_FIRST) begin
					col_sum[col][c] = part[COL_SUM_W-1:0];
					wrote = 1'b1;
				end else if (sub_row == SUB_MID) begin
					col_sum[col][c] = col_sum[col][c] + part[COL_SUM_W-1:0];
					wrote = 1'b1;
				end else begin
					total = 32'(col_sum[col][c]) + part;
					avg.chans[c] = CH_W'((total + BLOCK_AREA / 2) / BLOCK_AREA);
					emit = 1'b1;
				end
			end
			if (wrote && col == written_prefix) written_prefix++;
			if (emit) begin
				avg.frame_done = last_col && last_row;
				avg_queue = {avg_queue, avg};
			end
			// advance the raster position
			if (sub_col != SUB_LAST) begin
				sub_col++;
			end else begin
				sub_col = SUB_FIRST;
				if (!last_col) begin
					out_col++;
				end else begin
					out_col = '0;
					if (sub_row != SUB_LAST) begin
						sub_row++;
					end else begin
						sub_row = SUB_FIRST;
						out_row = last_row ? '0 : out_row + 1'b1;
					end
				end
			end
		endfunction

		// Compare one output transaction with the oldest predicted average.
		function void check_avg(pixel_t data, logic last);
			string names [NUM_CH];
			box_avg_t want;
			int c;
			names = '{"red_out", "green_out", "blue_out"};
			if (avg_queue.size() == 0) begin
				$error("unexpected output: tdata %h, frame_done %b", data, last);
				fail_count++;
				return;
			end
			want = avg_queue.pop_front();
			for (c = 0; c < NUM_CH; c++) begin
				if (data[c] !== want.chans[c]) begin
					$error("%s mismatch: expected %0d, actual %0d", names[c], want.chans[c], data[c]);
					fail_count++;
				end
			end
			if (last !== want.frame_done) begin
				$error("frame_done mismatch: expected %0d, actual %0d", want.frame_done, last);
				fail_count++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [PIX_W-1:0] s_axis_tdata;  // red_in, green_in, blue_in
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [PIX_W-1:0] m_axis_tdata;  // red_out, green_out, blue_out
	logic m_axis_tlast;
	logic cfg_we;
	logic cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	box_avg_board sb;
	int sender_idle_pct = 0;
	int recv_stall_pct = 0;
	int rx_hold_cycles = 0;
	int cycle_count = 0;

	supersample_box_downsample_3x3 u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #2 clk = ~clk;

	// Offer one pixel after optional idle cycles and hold it until the transaction completes.
	task automatic send_pixel(input pixel_t px);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= px;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_pixel(px);
	endtask

	// Write both dimension registers on back-to-back cycles.
	task automatic write_dims(input logic [WIDTH_REG_W-1:0] w, input logic [HEIGHT_REG_W-1:0] h);
		cfg_we <= 1'b1;
		cfg_index <= REG_OUT_WIDTH;
		cfg_data <= CFG_DATA_W'(w);
		@(posedge clk);
		cfg_index <= REG_OUT_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_dims(w, h);
	endtask

	// Wait for every predicted average, then let the pipeline run empty.
	task automatic drain_block();
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Output side: check each transaction, then pick the next tready.
	initial begin
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
				sb.check_avg(m_axis_tdata, m_axis_tlast);
			if (rx_hold_cycles > 0) begin
				rx_hold_cycles--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Abort a hung run.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		pixel_t px;
		logic [WIDTH_REG_W-1:0] new_w;
		logic [HEIGHT_REG_W-1:0] new_h;
		int n_items;
		int phase;
		int i;
		int c;
		sb = new();
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_OUT_WIDTH;
		cfg_data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero registers clamp to a 1x1 output: full-scale block, then rounding edges
		write_dims('0, '0);
		for (i = 0; i < BLOCK_AREA; i++) send_pixel({NUM_CH{8'hFF}});
		for (i = 0; i < BLOCK_AREA; i++) begin
			px = '0;
			if (i == 0) begin
				px[0] = 8'd5;
				px[1] = 8'd4;
				px[2] = 8'd13;
			end
			send_pixel(px);
		end
		s_axis_tvalid <= 1'b0;

		for (phase = 0; phase < NUM_PHASES; phase++) begin
			drain_block();
			case (phase % 4)
				0: begin sender_idle_pct = 0; recv_stall_pct = 0; end
				1: begin sender_idle_pct = 74; recv_stall_pct = 0; end
				2: begin sender_idle_pct = 0; recv_stall_pct = 74; end
				default: begin sender_idle_pct = 34; recv_stall_pct = 34; end
			endcase
			// pick dimensions: extremes, out-of-range values and mostly small frames
			if (phase == 0) begin
				new_w = 11'd2047;
				new_h = 13'd8191;
			end else if (phase == PRESSURE_PHASE) begin
				new_w = 11'd1;
				new_h = 13'd2;
			end else begin
				case ($urandom_range(9))
					0: new_w = 11'd0;
					1: new_w = 11'd1;
					2: new_w = 11'd2047;
					3: new_w = 11'd1024;
					4: new_w = WIDTH_REG_W'($urandom_range(2047));
					default: new_w = WIDTH_REG_W'($urandom_range(6, 1));
				endcase
				case ($urandom_range(9))
					0: new_h = 13'd0;
					1: new_h = 13'd1;
					2: new_h = 13'd8191;
					3: new_h = 13'd4096;
					4: new_h = HEIGHT_REG_W'($urandom_range(8191));
					default: new_h = HEIGHT_REG_W'($urandom_range(4, 1));
				endcase
			end
			if (!sb.width_safe(new_w)) new_w = WIDTH_REG_W'(sb.reg_width);
			write_dims(new_w, new_h);
			// stall the output so the block backs up into its input
			if (phase == PRESSURE_PHASE) rx_hold_cycles = HOLD_OFF_CYCLES;
			n_items = $urandom_range(105, 85);
			for (i = 0; i < n_items; i++) begin
				for (c = 0; c < NUM_CH; c++) begin
					case ($urandom_range(7))
						0: px[c] = 8'd0;
						1: px[c] = 8'd255;
						default: px[c] = CH_W'($urandom_range(255));
					endcase
				end
				send_pixel(px);
			end
			s_axis_tvalid <= 1'b0;
		end

		drain_block();
		if (sb.fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/sbd_pkg.sv
rtl/sbd_raster.sv
rtl/sbd_accum.sv
rtl/supersample_box_downsample_3x3.sv
bench/supersample_box_downsample_3x3_tb.sv
